/* sv/fchc_pkg.sv */
// Shared widths, register defaults, codes and helpers for the fan curve controller.
package fchc_pkg;

   // field widths
   localparam int TEMP_W     = 12;
   localparam int RPM_W      = 16;
   localparam int SPEED_W    = 15;
   localparam int PCT_W      = 7;
   localparam int DEG_W      = 7;
   localparam int HYST_W     = 3;
   localparam int CONST_W    = 8;
   localparam int FRAC_W     = 4;   // sixteenths of a degree
   localparam int SPD_FRAC_W = 8;   // 1/256 percent
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // serial remap datapath
   localparam int MUL_A_W  = DEG_W + FRAC_W;            // offset into the range
   localparam int MUL_B_W  = PCT_W;                     // speed span
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_D_W  = DEG_W;                     // range span in degrees
   localparam int DIV_Q_W  = SPEED_W;
   localparam int DIV_N_W  = MUL_P_W + FRAC_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   // register defaults
   localparam logic [HYST_W-1:0]  HYST_RST       = 3'd3;
   localparam logic [DEG_W-1:0]   TEMP_LOW_RST   = 7'd45;
   localparam logic [DEG_W-1:0]   TEMP_HIGH_RST  = 7'd75;
   localparam logic [PCT_W-1:0]   IDLE_SPD_RST   = 7'd25;
   localparam logic [PCT_W-1:0]   RLOW_SPD_RST   = 7'd25;
   localparam logic [PCT_W-1:0]   RHIGH_SPD_RST  = 7'd75;
   localparam logic [PCT_W-1:0]   HEAT_SPD_RST   = 7'd100;
   localparam logic [CONST_W-1:0] CONST_SPD_RST  = 8'hFF;

   localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
   localparam logic [SPEED_W-1:0] FULL_SPEED = 15'd25600;

   typedef enum logic [2:0] {
      REG_IDLE  = 3'd0,
      REG_HEAT  = 3'd1,
      REG_RANGE = 3'd2,
      REG_CONST = 3'd3,
      REG_STALL = 3'd4
   } regime_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HYST      = 3'd0,
      CSR_TEMP_LOW  = 3'd1,
      CSR_TEMP_HIGH = 3'd2,
      CSR_IDLE_SPD  = 3'd3,
      CSR_RLOW_SPD  = 3'd4,
      CSR_RHIGH_SPD = 3'd5,
      CSR_HEAT_SPD  = 3'd6,
      CSR_CONST_SPD = 3'd7
   } csr_index_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // clamp a percent register to 100
   function automatic logic [PCT_W-1:0] pct_sat(input logic [PCT_W-1:0] v);
      pct_sat = (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

   // whole percent to 1/256 percent
   function automatic logic [SPEED_W-1:0] to_speed(input logic [PCT_W-1:0] p);
      to_speed = {p, {SPD_FRAC_W{1'b0}}};
   endfunction

   // magnitude of a signed temperature, fits unsigned in the same width
   function automatic logic [TEMP_W-1:0] temp_mag(input logic [TEMP_W-1:0] t);
      temp_mag = t[TEMP_W-1] ? (~t + 1'b1) : t;
   endfunction

endpackage

/* sv/fchc_if.sv */
// Handshake channel interfaces: sample requests, results and register writes.
interface fchc_req_if import fchc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic [RPM_W-1:0]         tach_rpm;
   logic                     tach_present;

   modport source (output valid, output temperature, output tach_rpm,
                   output tach_present, input ready);
   modport sink   (input valid, input temperature, input tach_rpm,
                   input tach_present, output ready);
endinterface

interface fchc_rsp_if import fchc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [SPEED_W-1:0]       drive_speed;
   logic                     spin_up;
   logic                     recomputed;
   logic signed [TEMP_W-1:0] held_temperature;
   logic                     fan_ok;
   logic [2:0]               regime;

   modport source (output valid, output drive_speed, output spin_up, output recomputed,
                   output held_temperature, output fan_ok, output regime, input ready);
   modport sink   (input valid, input drive_speed, input spin_up, input recomputed,
                   input held_temperature, input fan_ok, input regime, output ready);
endinterface

interface fchc_csr_if import fchc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/fchc_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle.
module fchc_mul import fchc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output unit_sts_type       sts,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_A_W-1:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]   lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic                 last;
   logic [MUL_A_W:0]     sum;

   assign last = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));

   // add the multiplicand when the low bit is set, then shift right
   always_comb begin
      sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      hi_in = sum[MUL_A_W:1];
      lo_in = {sum[0], lo_ff[MUL_B_W-1:1]};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff & last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            busy_ff <= ~last;
            cnt_ff  <= cnt_ff + 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign product  = {hi_ff, lo_ff};
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

/* sv/fchc_div.sv */
// Restoring divider, one quotient bit per cycle; the quotient must fit DIV_Q_W bits.
module fchc_div import fchc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] num,
   input  logic [DIV_D_W-1:0] den,
   output unit_sts_type       sts,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [DIV_D_W-1:0]   den_ff;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   sh_ff, sh_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic                 last;
   logic [DIV_D_W:0]     part, diff;
   logic                 ge;

   assign last = (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1));

   // bring down the next numerator bit, subtract if it fits
   always_comb begin
      part   = {rem_ff, sh_ff[DIV_Q_W-1]};
      ge     = (part >= {1'b0, den_ff});
      diff   = part - {1'b0, den_ff};
      rem_in = ge ? diff[DIV_D_W-1:0] : part[DIV_D_W-1:0];
      sh_in  = {sh_ff[DIV_Q_W-2:0], ge};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff & last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            busy_ff <= ~last;
            cnt_ff  <= cnt_ff + 1'b1;
         end
      end
   end

   // upper numerator bits are already below the divisor
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= num[DIV_N_W-1:DIV_Q_W];
         sh_ff  <= num[DIV_Q_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
      end
   end

   assign quotient = sh_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

/* sv/fan_curve_hysteresis_controller_core.sv */
// Fan curve controller top level: registers, sequencer, hysteresis and stall handling.
//
//   channel  direction  accepted when          payload
//   req_ch   in         valid & ready          temperature, tach_rpm, tach_present
//   rsp_ch   out        valid & ready          drive_speed, spin_up, recomputed,
//                                              held_temperature, fan_ok, regime
//   csr_ch   in         valid & ready (ready   index, data
//                       is always high)
//
// A request goes through the states accept (idle), check and finish, and the result is
// registered in finish; inside the linear range, when a recompute is due and no stall is
// held, the serial multiplier and then the divider run between check and finish.
// One request is in work at a time; the next is accepted as soon as the previous result
// sits in the output register, even while rsp_ch is stalled.
// Reset is synchronous and loads the register defaults and clears the fan state.
module fan_curve_hysteresis_controller_core import fchc_pkg::*; (
   input logic       clock,
   input logic       reset,
   fchc_req_if.sink   req_ch,
   fchc_rsp_if.source rsp_ch,
   fchc_csr_if.sink   csr_ch
);

   // configuration registers
   logic [HYST_W-1:0]  hyst_ff;
   logic [DEG_W-1:0]   tlow_ff, thigh_ff;
   logic [PCT_W-1:0]   idle_ff, rlow_ff, rhigh_ff, heat_ff;
   logic [CONST_W-1:0] const_ff;

   // fan state
   logic               speed_valid_ff;
   logic [TEMP_W-1:0]  held_temp_ff;
   logic [SPEED_W-1:0] last_speed_ff;
   logic               stall_ff;
   regime_type         last_regime_ff;

   // request in work
   state_type          state_ff, state_in;
   logic [TEMP_W-1:0]  temp_ff;
   logic               present_ff, rpm_nz_ff;
   logic               recomp_ff;
   logic [SPEED_W-1:0] new_speed_ff;
   regime_type         new_regime_ff;
   logic               neg_ff;

   // result register
   logic               rsp_valid_ff;
   logic [SPEED_W-1:0] rsp_drive_ff;
   logic               rsp_spin_ff, rsp_recomp_ff, rsp_ok_ff;
   logic [TEMP_W-1:0]  rsp_held_ff;
   regime_type         rsp_regime_ff;

   // sequencer outputs
   logic req_ready, check_en, mul_start, div_start, finish_en, out_free;

   // serial units
   unit_sts_type       mul_sts, div_sts;
   logic [MUL_P_W-1:0] mul_p;
   logic [DIV_Q_W-1:0] div_q;

   // ---------------------------------------------------------------
   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff  <= HYST_RST;
         tlow_ff  <= TEMP_LOW_RST;
         thigh_ff <= TEMP_HIGH_RST;
         idle_ff  <= IDLE_SPD_RST;
         rlow_ff  <= RLOW_SPD_RST;
         rhigh_ff <= RHIGH_SPD_RST;
         heat_ff  <= HEAT_SPD_RST;
         const_ff <= CONST_SPD_RST;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_HYST:      hyst_ff  <= csr_ch.data[HYST_W-1:0];
            CSR_TEMP_LOW:  tlow_ff  <= csr_ch.data[DEG_W-1:0];
            CSR_TEMP_HIGH: thigh_ff <= csr_ch.data[DEG_W-1:0];
            CSR_IDLE_SPD:  idle_ff  <= csr_ch.data[PCT_W-1:0];
            CSR_RLOW_SPD:  rlow_ff  <= csr_ch.data[PCT_W-1:0];
            CSR_RHIGH_SPD: rhigh_ff <= csr_ch.data[PCT_W-1:0];
            CSR_HEAT_SPD:  heat_ff  <= csr_ch.data[PCT_W-1:0];
            CSR_CONST_SPD: const_ff <= csr_ch.data[CONST_W-1:0];
            default:       ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // hysteresis check and curve selection
   logic                     const_on, changed, need;
   logic [TEMP_W-1:0]        t_mag, h_mag, t_diff;
   logic signed [TEMP_W:0]   t_ext, lo_ext, hi_ext, rng_off;
   logic                     below, above;
   logic [PCT_W-1:0]         slo, shi, ds_mag;
   logic                     ds_neg, span_zero, cls_serial;
   logic [DEG_W-1:0]         span;
   logic [SPEED_W-1:0]       cls_speed, base_speed;
   regime_type               cls_regime;

   always_comb begin
      const_on = ~const_ff[CONST_W-1];
      t_mag    = temp_mag(temp_ff);
      h_mag    = temp_mag(held_temp_ff);
      t_diff   = (t_mag >= h_mag) ? (t_mag - h_mag) : (h_mag - t_mag);
      changed  = ~const_on &
                 (t_diff >= TEMP_W'({hyst_ff, {FRAC_W{1'b0}}}));
      need     = changed | ~speed_valid_ff;

      t_ext    = $signed({temp_ff[TEMP_W-1], temp_ff});
      lo_ext   = $signed({2'b00, tlow_ff, {FRAC_W{1'b0}}});
      hi_ext   = $signed({2'b00, thigh_ff, {FRAC_W{1'b0}}});
      below    = (t_ext < lo_ext);
      above    = (t_ext > hi_ext);
      rng_off  = t_ext - lo_ext;

      slo        = pct_sat(rlow_ff);
      shi        = pct_sat(rhigh_ff);
      ds_neg     = (shi < slo);
      ds_mag     = ds_neg ? (slo - shi) : (shi - slo);
      span       = thigh_ff - tlow_ff;
      span_zero  = (thigh_ff == tlow_ff);
      base_speed = to_speed(slo);

      cls_serial = 1'b0;
      if (const_on) begin
         cls_speed  = to_speed(pct_sat(const_ff[PCT_W-1:0]));
         cls_regime = REG_CONST;
      end else if (below) begin
         cls_speed  = to_speed(pct_sat(idle_ff));
         cls_regime = REG_IDLE;
      end else if (above) begin
         cls_speed  = to_speed(pct_sat(heat_ff));
         cls_regime = REG_HEAT;
      end else begin
         cls_speed  = base_speed;
         cls_regime = REG_RANGE;
         cls_serial = ~span_zero;
      end
   end

   // ---------------------------------------------------------------
   // remap: (offset * speed span * 16) / degree span
   fchc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (rng_off[MUL_A_W-1:0]),
      .b       (ds_mag),
      .sts     (mul_sts),
      .product (mul_p)
   );

   fchc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      ({mul_p, {FRAC_W{1'b0}}}),
      .den      (span),
      .sts      (div_sts),
      .quotient (div_q)
   );

   // ---------------------------------------------------------------
   // sequencer: next state
   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_ch.valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = (~stall_ff & need & cls_serial) ? ST_MUL : ST_FINISH;
         ST_MUL:    if (mul_sts.done) state_in = ST_DIV;
         ST_DIV:    if (div_sts.done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      check_en  = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      finish_en = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_CHECK: begin
            check_en  = 1'b1;
            mul_start = ~stall_ff & need & cls_serial;
         end
         ST_MUL:    div_start = mul_sts.done;
         ST_DIV:    ;
         ST_FINISH: finish_en = out_free;
         default:   ;
      endcase
   end

   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------
   // closing a request: stall handling, state update, result
   logic               stall_clear, stall_hit, spin;
   logic [SPEED_W-1:0] upd_speed, idle_speed;
   regime_type         upd_regime;
   logic [TEMP_W-1:0]  upd_held;

   always_comb begin
      stall_clear = present_ff & rpm_nz_ff;
      upd_speed   = recomp_ff ? new_speed_ff : last_speed_ff;
      upd_regime  = recomp_ff ? new_regime_ff : last_regime_ff;
      upd_held    = recomp_ff ? temp_ff : held_temp_ff;
      idle_speed  = to_speed(pct_sat(idle_ff));
      spin        = recomp_ff & (new_speed_ff != '0) &
                    (~speed_valid_ff | (last_speed_ff == '0) | (last_speed_ff < idle_speed));
      stall_hit   = present_ff & (upd_speed != '0) & ~rpm_nz_ff;
   end

   // control and fan state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         speed_valid_ff <= 1'b0;
         held_temp_ff   <= '0;
         last_speed_ff  <= '0;
         stall_ff       <= 1'b0;
         last_regime_ff <= REG_IDLE;
      end else begin
         if (finish_en) begin
            rsp_valid_ff <= 1'b1;
            if (stall_ff) begin
               if (stall_clear) stall_ff <= 1'b0;
            end else begin
               if (recomp_ff) begin
                  speed_valid_ff <= 1'b1;
                  held_temp_ff   <= temp_ff;
                  last_speed_ff  <= new_speed_ff;
                  last_regime_ff <= new_regime_ff;
               end
               if (stall_hit) stall_ff <= 1'b1;
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request payload and result payload
   always_ff @(posedge clock) begin
      if (req_ch.valid & req_ready) begin
         temp_ff    <= req_ch.temperature;
         present_ff <= req_ch.tach_present;
         rpm_nz_ff  <= (req_ch.tach_rpm != '0);
      end
      if (check_en) begin
         recomp_ff     <= ~stall_ff & need;
         new_speed_ff  <= cls_speed;
         new_regime_ff <= cls_regime;
         neg_ff        <= ds_neg;
      end else if (div_sts.done) begin
         new_speed_ff <= neg_ff ? (base_speed - div_q) : (base_speed + div_q);
      end
      if (finish_en) begin
         if (stall_ff) begin
            rsp_drive_ff  <= stall_clear ? last_speed_ff : FULL_SPEED;
            rsp_ok_ff     <= stall_clear;
            rsp_spin_ff   <= 1'b0;
            rsp_recomp_ff <= 1'b0;
            rsp_held_ff   <= held_temp_ff;
            rsp_regime_ff <= REG_STALL;
         end else begin
            rsp_drive_ff  <= stall_hit ? FULL_SPEED : upd_speed;
            rsp_ok_ff     <= ~stall_hit;
            rsp_spin_ff   <= spin;
            rsp_recomp_ff <= recomp_ff;
            rsp_held_ff   <= upd_held;
            rsp_regime_ff <= stall_hit ? REG_STALL : upd_regime;
         end
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.drive_speed      = rsp_drive_ff;
   assign rsp_ch.spin_up          = rsp_spin_ff;
   assign rsp_ch.recomputed       = rsp_recomp_ff;
   assign rsp_ch.held_temperature = rsp_held_ff;
   assign rsp_ch.fan_ok           = rsp_ok_ff;
   assign rsp_ch.regime           = rsp_regime_ff;

   // ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // entering a stall always reports it in the result just loaded
   a_stall_report: assert property (@(posedge clock) disable iff (reset)
      $rose(stall_ff) |-> rsp_valid_ff && rsp_regime_ff == REG_STALL && !rsp_ok_ff)
      else $error("stall entered without a stall result");

   // the serial units are quiet whenever a new request can be taken
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_sts.busy && !div_sts.busy)
      else $error("serial unit busy while sequencer idle");

   // the remap never leaves the 0..100 percent scale
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_drive_ff <= FULL_SPEED)
      else $error("drive speed above full scale");

   // a recompute always leaves a valid held speed behind
   a_recomp_valid: assert property (@(posedge clock) disable iff (reset)
      finish_en && recomp_ff && !stall_ff |=> speed_valid_ff && rsp_recomp_ff)
      else $error("recompute did not mark speed valid");
`endif

endmodule
